// ===== design/ausfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ausfc_pkg: shared types and constants for the au sample format converter
// Result record, converter outputs, format and register codes, mu-law tables.
// ----------------------------------------------------------------------------
package ausfc_pkg;

	// Register indexes on the configuration port
	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_FORMAT    = 1'b1;

	// Direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Sample format codes
	localparam logic [1:0] FMT_MULAW  = 2'd0;
	localparam logic [1:0] FMT_LIN8   = 2'd1;
	localparam logic [1:0] FMT_LIN16  = 2'd2;
	localparam logic [1:0] FMT_UNUSED = 2'd3;

	// G.711 mu-law constants
	localparam logic [16:0] MU_CLIP = 17'd32635;
	localparam logic [14:0] MU_BIAS = 15'h0084;

	// Result queue: power of two, room for two requests in flight
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// One result request on the output channel
	typedef struct packed {
		logic [7:0]         au_byte_out;
		logic signed [23:0] wide_sample_out;
		logic               last;
	} res_t;

	// Everything the converter hands back for one input request
	typedef struct packed {
		logic [1:0] n_res;
		res_t       r0;
		res_t       r1;
		logic       pend_valid;
		logic [7:0] pend_byte;
	} conv_t;

	// Segment base of the mu-law decoder
	function automatic logic [14:0] mu_seg_base(input logic [2:0] seg);
		logic [14:0] b;
		case (seg)
			3'd0:    b = 15'd0;
			3'd1:    b = 15'd132;
			3'd2:    b = 15'd396;
			3'd3:    b = 15'd924;
			3'd4:    b = 15'd1980;
			3'd5:    b = 15'd4092;
			3'd6:    b = 15'd8316;
			default: b = 15'd16764;
		endcase
		return b;
	endfunction

endpackage

// ===== design/ausfc_convert.sv =====
// ----------------------------------------------------------------------------
// ausfc_convert: single-pass sample conversion
// Encodes a scaled sample into 1 or 2 au bytes, or decodes au bytes into a
// scaled sample, including the high-byte pairing of linear 16 decode.
// ----------------------------------------------------------------------------
module ausfc_convert (
	input  logic                direction,
	input  logic [1:0]          sample_format,
	input  logic signed [31:0]  wide_sample,
	input  logic [7:0]          au_byte,
	input  logic                pending_valid,
	input  logic [7:0]          pending_high_byte,
	output ausfc_pkg::conv_t    conv
);
	import ausfc_pkg::*;

	// G.711 mu-law encode, no zero trap
	function automatic logic [7:0] mu_enc(input logic signed [15:0] s);
		logic        sign;
		logic [16:0] mag;
		logic [14:0] m;
		logic [2:0]  seg;
		logic [3:0]  mant;
		sign = s[15];
		mag  = sign ? (17'd0 - {s[15], s}) : {1'b0, s};
		if (mag > MU_CLIP) mag = MU_CLIP;
		m   = mag[14:0] + MU_BIAS;
		seg = 3'd0;
		// highest set bit among 8..14 sets the segment
		for (int k = 8; k <= 14; k++) begin
			if (m[k]) seg = 3'(k - 7);
		end
		// shift reaches 10, so it needs four bits
		mant = 4'(m >> ({1'b0, seg} + 4'd3));
		return ~{sign, seg, mant};
	endfunction

	// G.711 mu-law decode to 16-bit linear
	function automatic logic signed [15:0] mu_dec(input logic [7:0] b);
		logic [7:0]  c;
		logic [14:0] mag;
		c   = ~b;
		mag = mu_seg_base(c[6:4]) + ({11'd0, c[3:0]} << ({1'b0, c[6:4]} + 4'd3));
		return c[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic signed [23:0] sh8;
	logic signed [15:0] sh16;
	logic signed [15:0] sat16;
	logic [7:0]         sat8;

	// Floor shift (arithmetic) and saturate for encode
	always_comb begin
		sh8  = wide_sample[31:8];
		sh16 = wide_sample[31:16];
		if (sh8 > 24'sd32767)       sat16 = 16'sh7fff;
		else if (sh8 < -24'sd32768) sat16 = 16'sh8000;
		else                        sat16 = sh8[15:0];
		if (sh16 > 16'sd127)        sat8 = 8'h7f;
		else if (sh16 < -16'sd128)  sat8 = 8'h80;
		else                        sat8 = sh16[7:0];
	end

	// Result selection and pairing state
	always_comb begin
		conv            = '0;
		conv.pend_valid = pending_valid;
		conv.pend_byte  = pending_high_byte;
		if (sample_format == FMT_UNUSED) begin
			// request dropped, state untouched
			conv.n_res = 2'd0;
		end else if (direction == DIR_ENCODE) begin
			conv.pend_valid = 1'b0;
			case (sample_format)
				FMT_MULAW: begin
					conv.n_res          = 2'd1;
					conv.r0.au_byte_out = mu_enc(sat16);
					conv.r0.last        = 1'b1;
				end
				FMT_LIN8: begin
					conv.n_res          = 2'd1;
					conv.r0.au_byte_out = sat8;
					conv.r0.last        = 1'b1;
				end
				default: begin
					// big-endian: high byte first
					conv.n_res          = 2'd2;
					conv.r0.au_byte_out = sat16[15:8];
					conv.r1.au_byte_out = sat16[7:0];
					conv.r1.last        = 1'b1;
				end
			endcase
		end else begin
			case (sample_format)
				FMT_MULAW: begin
					conv.pend_valid         = 1'b0;
					conv.n_res              = 2'd1;
					conv.r0.wide_sample_out = {mu_dec(au_byte), 8'h00};
					conv.r0.last            = 1'b1;
				end
				FMT_LIN8: begin
					conv.pend_valid         = 1'b0;
					conv.n_res              = 2'd1;
					conv.r0.wide_sample_out = {au_byte, 16'h0000};
					conv.r0.last            = 1'b1;
				end
				default: begin
					if (!pending_valid) begin
						// hold the high byte, no result yet
						conv.pend_valid = 1'b1;
						conv.pend_byte  = au_byte;
						conv.n_res      = 2'd0;
					end else begin
						conv.pend_valid         = 1'b0;
						conv.n_res              = 2'd1;
						conv.r0.wide_sample_out = {pending_high_byte, au_byte, 8'h00};
						conv.r0.last            = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ===== design/au_sample_format_converter_unit.sv =====
// ----------------------------------------------------------------------------
// au_sample_format_converter_unit: au sample encoder / decoder
// Converts between 32-bit scaled samples and au bytes (mu-law, linear 8/16).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries wide_sample and au_byte; only
//   the field matching the direction is used. Output channel
//   (out_valid/out_ready) carries au_byte_out, wide_sample_out and last.
//   Configure direction (index 0) and sample_format (index 1) through
//   cfg_we/cfg_index/cfg_data while no request is in flight; any write
//   drops a held linear 16 high byte.
//   An accepted request is held in the input register, then converted and
//   written to the result queue, from whose head its first result is offered.
//   Throughput: one request per cycle while the result queue has room;
//   linear 16 encode emits two results per request, so in that mode the
//   output port (one result per cycle) limits the rate. Linear 16 decode
//   gives one result per two requests; an unused format code gives none.
//   in_ready depends on the fill of an 8-entry result queue: a stalled
//   receiver fills it and then in_ready drops; nothing is lost.
//   Reset clears the configuration (encode, mu-law), the pairing state and
//   the queue.
// ----------------------------------------------------------------------------
module au_sample_format_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] wide_sample,
	input  logic [7:0]         au_byte,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         au_byte_out,
	output logic signed [23:0] wide_sample_out,
	output logic               last
);
	import ausfc_pkg::*;

	logic               direction_q;
	logic [1:0]         sample_format_q;
	logic               pending_valid_q;
	logic [7:0]         pending_high_byte_q;

	logic               valid_s1;
	logic signed [31:0] wide_sample_s1;
	logic [7:0]         au_byte_s1;

	conv_t              conv;

	res_t               oq_mem [OQ_DEPTH];
	logic [OQ_AW-1:0]   wr_ptr_q;
	logic [OQ_AW-1:0]   rd_ptr_q;
	logic [OQ_CW-1:0]   count_q;

	logic               in_fire;
	logic               pop;
	logic [1:0]         push_n;
	logic [OQ_CW:0]     need;
	res_t               head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q     <= DIR_ENCODE;
			sample_format_q <= FMT_MULAW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: direction_q     <= cfg_data[0];
				REG_FORMAT:    sample_format_q <= cfg_data;
			endcase
		end
	end

	// Input register
	assign in_fire = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wide_sample_s1 <= wide_sample;
			au_byte_s1     <= au_byte;
		end
	end

	// Conversion
	ausfc_convert u_convert (
		.direction         (direction_q),
		.sample_format     (sample_format_q),
		.wide_sample       (wide_sample_s1),
		.au_byte           (au_byte_s1),
		.pending_valid     (pending_valid_q),
		.pending_high_byte (pending_high_byte_q),
		.conv              (conv)
	);

	// Linear 16 pairing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
		end else if (cfg_we) begin
			pending_valid_q <= 1'b0;
		end else if (valid_s1) begin
			pending_valid_q <= conv.pend_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pending_high_byte_q <= conv.pend_byte;
		end
	end

	// Result queue
	assign push_n = valid_s1 ? conv.n_res : 2'd0;
	assign pop    = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			oq_mem[wr_ptr_q] <= conv.r0;
		end
		if (push_n == 2'd2) begin
			oq_mem[OQ_AW'(wr_ptr_q + 1'b1)] <= conv.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQ_CW'(push_n) - OQ_CW'(pop);
		end
	end

	// Accept only when the queue can absorb what is in flight plus two more
	always_comb begin
		need = (OQ_CW+1)'(count_q) + (valid_s1 ? (OQ_CW+1)'(2) : '0) + (OQ_CW+1)'(2);
	end
	assign in_ready = (need <= (OQ_CW+1)'(OQ_DEPTH));

	// Output
	assign head            = oq_mem[rd_ptr_q];
	assign out_valid       = (count_q != '0);
	assign au_byte_out     = head.au_byte_out;
	assign wide_sample_out = head.wide_sample_out;
	assign last            = head.last;

endmodule

// ===== design/ausfc_checker.sv =====
// ----------------------------------------------------------------------------
// ausfc_checker: port-level checks for the au sample format converter
// Watches the output channel for stall behavior and result framing.
// ----------------------------------------------------------------------------
module ausfc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         au_byte_out,
	input logic signed [23:0] wide_sample_out,
	input logic               last
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(au_byte_out)
			&& $stable(wide_sample_out) && $stable(last))
		else $error("output result changed while stalled");

	// A high byte taken is followed at once by its low byte, marked last
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last)
		else $error("linear 16 low byte missing after high byte");

	// Encode results carry no sample, decode results carry no byte
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (au_byte_out == 8'h00) || (wide_sample_out == 24'sd0))
		else $error("result carries both a byte and a sample");

	// Decoded samples always close their request
	a_decode_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (wide_sample_out != 24'sd0) |-> last)
		else $error("decoded sample not marked last");

endmodule

bind au_sample_format_converter_unit ausfc_checker u_ausfc_checker (.*);

// ===== bench/au_sample_format_converter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// au_sample_format_converter_unit_tb: self-checking bench for the converter
// Runs directed corner requests and then randomized phases over every
// direction and format. An in-bench model predicts each result, and every
// result is compared field by field in arrival order. Both channels idle in
// random bursts, and one long receiver stall backs up the input channel.
// ----------------------------------------------------------------------------
module au_sample_format_converter_unit_tb;
	import ausfc_pkg::*;

	localparam int IDLE_LIMIT = 2000;  // cycles with no request moving
	localparam int HOLD_CYCLES = 150;  // long receiver stall
	localparam int N_ITEMS = 1400;

	// Expected-result model and in-order result checker
	class au_conversion_checker;
		logic       dir;
		logic [1:0] fmt;
		logic [7:0] held_hi;
		bit         held_ok;
		res_t       due_results[$];
		int         errors;

		function new();
			dir = DIR_ENCODE;
			fmt = FMT_MULAW;
			held_hi = '0;
			held_ok = 0;
			errors = 0;
		endfunction

		// Any register write drops a held high byte
		function void note_write(logic idx, logic [1:0] val);
			if (idx == REG_DIRECTION)
				dir = val[0];
			else
				fmt = val;
			held_ok = 0;
		endfunction

		// G.711 mu-law encode, bias and clip, no zero trap
		function logic [7:0] mu_law_byte(logic signed [15:0] s);
			logic       sgn;
			int         mag;
			int         seg;
			logic [3:0] mant;
			sgn = (s < 0);
			mag = sgn ? -int'(s) : int'(s);
			if (mag > int'(MU_CLIP))
				mag = int'(MU_CLIP);
			mag += int'(MU_BIAS);
			seg = 0;
			for (int k = 8; k <= 14; k++)
				if (mag[k])
					seg = k - 7;
			mant = 4'(mag >> (seg + 3));
			return ~{sgn, seg[2:0], mant};
		endfunction

		// mu-law decode; segment base is 132 * (2^seg - 1)
		function int mu_law_value(logic [7:0] b);
			logic [7:0] c;
			int         mag;
			c = ~b;
			mag = ((132 << c[6:4]) - 132) + (int'(c[3:0]) << (c[6:4] + 3));
			return c[7] ? -mag : mag;
		endfunction

		// Work out the results of one accepted request
		function void note_input(logic signed [31:0] w, logic [7:0] b);
			res_t              r;
			logic signed [31:0] t;
			logic [15:0]       s16;
			int                v;
			if (fmt == FMT_UNUSED)
				return;
			r = '0;
			r.last = 1'b1;
			if (dir == DIR_ENCODE) begin
				held_ok = 0;
				if (fmt == FMT_LIN8) begin
					t = w >>> 16;
					r.au_byte_out = (t > 127) ? 8'h7f : (t < -128) ? 8'h80 : t[7:0];
					due_results.push_back(r);
				end else begin
					t = w >>> 8;
					s16 = (t > 32767) ? 16'h7fff : (t < -32768) ? 16'h8000 : t[15:0];
					if (fmt == FMT_MULAW) begin
						r.au_byte_out = mu_law_byte(s16);
						due_results.push_back(r);
					end else begin
						// high byte first, low byte carries last
						r.au_byte_out = s16[15:8];
						r.last = 1'b0;
						due_results.push_back(r);
						r.au_byte_out = s16[7:0];
						r.last = 1'b1;
						due_results.push_back(r);
					end
				end
			end else if (fmt == FMT_MULAW) begin
				held_ok = 0;
				v = mu_law_value(b);
				r.wide_sample_out = 24'(v * 256);
				due_results.push_back(r);
			end else if (fmt == FMT_LIN8) begin
				held_ok = 0;
				r.wide_sample_out = {b, 16'h0000};
				due_results.push_back(r);
			end else if (!held_ok) begin
				held_hi = b;
				held_ok = 1;
			end else begin
				held_ok = 0;
				r.wide_sample_out = {held_hi, b, 8'h00};
				due_results.push_back(r);
			end
		endfunction

		// Compare one result request with the oldest expectation
		function void check_result(logic [7:0] ab, logic signed [23:0] ws, logic lst);
			res_t e;
			if (due_results.size() == 0) begin
				$error("unexpected result: au_byte_out=%h wide_sample_out=%h last=%b",
					ab, ws, lst);
				errors++;
				return;
			end
			e = due_results.pop_front();
			if (ab !== e.au_byte_out) begin
				$error("au_byte_out: expected %h, actual %h", e.au_byte_out, ab);
				errors++;
			end
			if (ws !== e.wide_sample_out) begin
				$error("wide_sample_out: expected %h, actual %h", e.wide_sample_out, ws);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %b, actual %b", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [1:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] wide_sample;
	logic [7:0]         au_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         au_byte_out;
	logic signed [23:0] wide_sample_out;
	logic               last;

	au_conversion_checker sb = new();

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	bit hold_out = 0;
	int n_sent = 0;

	au_sample_format_converter_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.wide_sample     (wide_sample),
		.au_byte         (au_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.au_byte_out     (au_byte_out),
		.wide_sample_out (wide_sample_out),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(wide_sample, au_byte);
			if (out_valid && out_ready)
				sb.check_result(au_byte_out, wide_sample_out, last);
		end
	end

	// Stall watchdog
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("simulation failed");
		$finish;
	end

	// Receiver: random backpressure bursts and one long hold
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 0;
				out_ready <= 1'b1;
			end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until accepted
	task automatic send_req(input logic signed [31:0] w, input logic [7:0] b);
		int gap;
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		wide_sample <= w;
		au_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drain, then write both registers back to back
	task automatic configure(input logic d, input logic [1:0] f);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIRECTION;
		cfg_data <= {1'($urandom_range(0, 1)), d};
		@(posedge clk);
		sb.note_write(REG_DIRECTION, {1'b0, d});
		cfg_index <= REG_FORMAT;
		cfg_data <= f;
		@(posedge clk);
		sb.note_write(REG_FORMAT, f);
		cfg_we <= 1'b0;
	endtask

	// Internal sample biased toward saturation and clip boundaries
	function automatic logic signed [31:0] pick_wide();
		logic signed [31:0] v;
		logic signed [23:0] mid;
		logic signed [11:0] tiny;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: begin
				mid = 24'($urandom);
				v = 32'(mid);
			end
			2: begin
				v = 32635 * 256 + $urandom_range(0, 1023) - 512;
				if ($urandom_range(0, 1))
					v = -v;
			end
			3: begin
				v = 127 * 65536 + $urandom_range(0, 131071) - 65536;
				if ($urandom_range(0, 1))
					v = -v;
			end
			4: begin
				tiny = 12'($urandom);
				v = 32'(tiny);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7fffffff;
					1: v = 32'h80000000;
					2: v = '0;
					default: v = '1;
				endcase
			end
		endcase
		return v;
	endfunction

	// One randomized phase at a fixed setting; optionally stall the receiver
	task automatic run_phase(input logic d, input logic [1:0] f, input int n,
		input bit hold = 1'b0);
		configure(d, f);
		if (hold)
			hold_out = 1;
		repeat (n) begin
			if (d == DIR_ENCODE)
				send_req(pick_wide(), 8'($urandom));
			else
				send_req(32'($urandom), 8'($urandom_range(0, 255)));
			if (f != FMT_UNUSED)
				n_sent++;
		end
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 15;
			2: return 40;
			default: return 70;
		endcase
	endfunction

	initial begin
		logic       d;
		logic [1:0] f;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DIRECTION;
		cfg_data <= '0;
		in_valid <= 1'b0;
		wide_sample <= '0;
		au_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encode corners: full scale, floor of small negatives, mu-law clip
		configure(DIR_ENCODE, FMT_MULAW);
		send_req(32'h7fffffff, 8'h00);
		send_req(32'h80000000, 8'hff);
		send_req(-32'sd1, 8'h00);
		send_req(32'sd8354560, 8'h00);
		send_req(-32'sd8354816, 8'h00);
		configure(DIR_ENCODE, FMT_LIN8);
		send_req(32'h7fffffff, 8'h00);
		send_req(32'h80000000, 8'h00);
		send_req(-32'sd1, 8'h00);
		send_req(32'h0000ffff, 8'h00);
		configure(DIR_ENCODE, FMT_LIN16);
		send_req(32'h7fffffff, 8'h00);
		send_req(32'h80000000, 8'h00);
		send_req(-32'sd256, 8'h00);

		// Decode corners, linear 16 pairing and a pairing dropped by a write
		configure(DIR_DECODE, FMT_MULAW);
		send_req(32'h0, 8'h00);
		send_req(32'h0, 8'hff);
		send_req(32'h0, 8'h7f);
		send_req(32'h0, 8'h80);
		configure(DIR_DECODE, FMT_LIN8);
		send_req(32'h0, 8'h80);
		send_req(32'h0, 8'h7f);
		configure(DIR_DECODE, FMT_LIN16);
		send_req(32'h0, 8'h80);
		send_req(32'h0, 8'h00);
		send_req(32'h0, 8'h7f);
		send_req(32'h0, 8'hff);
		send_req(32'h0, 8'hab);
		configure(DIR_DECODE, FMT_LIN8);
		send_req(32'h0, 8'h01);

		// Unused format code: requests are swallowed
		configure(DIR_ENCODE, FMT_UNUSED);
		send_req(32'h7fffffff, 8'hff);
		send_req(32'h12345678, 8'h5a);

		// Every setting once, with the long receiver hold on linear 16 encode
		for (int i = 0; i < 6; i++) begin
			in_idle_pct = pick_pct();
			out_idle_pct = pick_pct();
			d = (i >= 3) ? DIR_DECODE : DIR_ENCODE;
			f = 2'(i % 3);
			run_phase(d, f, 60, (d == DIR_ENCODE && f == FMT_LIN16));
		end
		run_phase(DIR_DECODE, FMT_UNUSED, 5);

		// Random settings
		while (n_sent < N_ITEMS - 200) begin
			in_idle_pct = pick_pct();
			out_idle_pct = pick_pct();
			d = 1'($urandom_range(0, 1));
			f = 2'($urandom_range(0, 3));
			run_phase(d, f, (f == FMT_UNUSED) ? 4 : $urandom_range(30, 90));
		end

		// Closing stretch at full rate
		in_idle_pct = 0;
		out_idle_pct = 0;
		while (n_sent < N_ITEMS) begin
			d = 1'($urandom_range(0, 1));
			f = 2'($urandom_range(0, 2));
			run_phase(d, f, 50);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
